FILE: design/bfa_pkg.sv
// Shared constants, codes and types of the bitmap frame allocator.
// No dependencies; every other design file except bfa_ram imports this package.

package bfa_pkg;

  // Map geometry
  localparam int NUM_FRAMES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = NUM_FRAMES / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int FRAME_W    = ADDR_W + BIT_W;
  localparam int WCNT_W     = $clog2(MAP_WORDS + 1);

  // Frame count register
  localparam int CNT_W = 13;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ALREADY  = 2'd1,
    ST_NO_FREE  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_MOD,
    S_WRITE,
    S_DONE
  } state_t;

  // Operand of the word unit
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 set_bit;
    logic [BIT_W-1:0]     bit_idx;
  } unit_req_t;

  // Result of the word unit
  typedef struct packed {
    logic                 full;
    logic [BIT_W-1:0]     free_idx;
    logic [WORD_BITS-1:0] word_upd;
  } unit_rsp_t;

  // Bitmap memory control
  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } ram_ctl_t;

endpackage

FILE: design/bfa_req_if.sv
// Request channel of the frame allocator: valid/ready plus one request item.
// Depends on bfa_pkg for field widths.

interface bfa_req_if;
  import bfa_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [FRAME_W-1:0] page_frame;
  logic               user_bit;
  logic               write_bit;

  modport source (output valid, mode, page_frame, user_bit, write_bit, input ready);
  modport sink   (input valid, mode, page_frame, user_bit, write_bit, output ready);
endinterface

FILE: design/bfa_rsp_if.sv
// Response channel of the frame allocator: valid/ready plus one result item.
// Depends on bfa_pkg for field widths.

interface bfa_rsp_if;
  import bfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FRAME_W-1:0] frame_out;
  logic               present;
  logic               user_out;
  logic               write_out;

  modport source (output valid, status, frame_out, present, user_out, write_out,
                  input ready);
  modport sink   (input valid, status, frame_out, present, user_out, write_out,
                  output ready);
endinterface

FILE: design/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bfa_word_unit.sv
// Shared bitmap word unit: full test, lowest-free-bit search, bit set/clear.
// Depends on bfa_pkg for the unit request and response types.

module bfa_word_unit (
  input  bfa_pkg::unit_req_t req,
  output bfa_pkg::unit_rsp_t rsp
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] mask;

  // Select the addressed bit
  assign mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << req.bit_idx;

  // Full word, lowest clear bit, and the word with the addressed bit set or cleared
  always_comb begin
    rsp.full     = &req.word;
    rsp.free_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!req.word[j]) begin
        rsp.free_idx = BIT_W'(j);
      end
    end
    rsp.word_upd = req.set_bit ? (req.word | mask) : (req.word & ~mask);
  end

endmodule

FILE: design/bfa_ctrl.sv
// Sequencer of the frame allocator: request decode, word scan, bitmap update
// and result register. Depends on bfa_pkg and the request/response interfaces.

module bfa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  bfa_req_if.sink                    req,
  bfa_rsp_if.source                  rsp,
  input  logic [bfa_pkg::WCNT_W-1:0] words,
  input  logic [bfa_pkg::WORD_BITS-1:0] ram_rdata,
  output bfa_pkg::ram_ctl_t          ram_ctl,
  output bfa_pkg::unit_req_t         unit_req,
  input  bfa_pkg::unit_rsp_t         unit_rsp
);
  import bfa_pkg::*;

  state_t state, state_next;

  logic [MAP_WORDS-1:0] word_valid;
  logic                 rd_word_valid;
  logic [WORD_BITS-1:0] live_word;

  logic [WCNT_W-1:0]    rd_idx;
  logic                 chk_valid;
  logic [ADDR_W-1:0]    chk_idx;
  logic                 issue;
  logic                 chk_last;
  logic                 hit;

  logic [FRAME_W-1:0]   pf;
  logic                 user;
  logic                 wrb;
  logic [WORD_BITS-1:0] hit_word;
  logic [BIT_W-1:0]     hit_idx;
  logic [ADDR_W-1:0]    hit_addr;

  status_t              res_status;
  logic [FRAME_W-1:0]   res_frame;
  logic                 res_present;
  logic                 res_user;
  logic                 res_write;

  logic                 accept;
  logic                 out_load;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // Never-written words read as free
  assign live_word = rd_word_valid ? ram_rdata : '0;

  assign issue    = (rd_idx < words);
  assign chk_last = (WCNT_W'(chk_idx) == (words - WCNT_W'(1)));
  assign hit      = chk_valid && !unit_rsp.full;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.mode == MODE_FREE) begin
            state_next = (req.page_frame == '0) ? S_DONE : S_FREE_RD;
          end else if (req.page_frame != '0 || words == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_WRITE;
        end else if (chk_valid && chk_last) begin
          state_next = S_DONE;
        end
      end
      S_FREE_RD:  state_next = S_FREE_MOD;
      S_FREE_MOD: state_next = S_DONE;
      S_WRITE:    state_next = S_DONE;
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory and word unit controls
  always_comb begin
    ram_ctl.we       = 1'b0;
    ram_ctl.waddr    = pf[FRAME_W-1:BIT_W];
    ram_ctl.wdata    = unit_rsp.word_upd;
    ram_ctl.raddr    = rd_idx[ADDR_W-1:0];
    unit_req.word    = live_word;
    unit_req.set_bit = 1'b0;
    unit_req.bit_idx = pf[BIT_W-1:0];
    unique case (state)
      S_FREE_RD: begin
        ram_ctl.raddr = pf[FRAME_W-1:BIT_W];
      end
      S_FREE_MOD: begin
        ram_ctl.we = 1'b1;
      end
      S_WRITE: begin
        unit_req.word    = hit_word;
        unit_req.set_bit = 1'b1;
        unit_req.bit_idx = hit_idx;
        ram_ctl.we       = 1'b1;
        ram_ctl.waddr    = hit_addr;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp.valid  <= 1'b0;
      word_valid <= '0;
      chk_valid  <= 1'b0;
      rd_idx     <= '0;
    end else begin
      state <= state_next;
      if (ram_ctl.we) begin
        word_valid[ram_ctl.waddr] <= 1'b1;
      end
      // Advance the scan: one read issued and one word checked per cycle
      if (accept) begin
        rd_idx    <= '0;
        chk_valid <= 1'b0;
      end else if (state == S_SCAN) begin
        if (issue) begin
          rd_idx <= rd_idx + WCNT_W'(1);
        end
        chk_valid <= issue;
      end
      // Load the next result, else drop the current one once taken
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_word_valid <= word_valid[ram_ctl.raddr];
    if (state == S_SCAN) begin
      chk_idx <= rd_idx[ADDR_W-1:0];
    end
    if (accept) begin
      pf          <= req.page_frame;
      user        <= req.user_bit;
      wrb         <= req.write_bit;
      res_frame   <= (req.mode == MODE_ALLOC) ? req.page_frame : '0;
      res_present <= 1'b0;
      res_user    <= 1'b0;
      res_write   <= 1'b0;
      if (req.mode == MODE_FREE) begin
        res_status <= ST_BAD_FREE;
      end else if (req.page_frame != '0) begin
        res_status <= ST_ALREADY;
      end else begin
        res_status <= ST_NO_FREE;
      end
    end
    // Hold the first word with a clear bit
    if (state == S_SCAN && hit) begin
      hit_word <= live_word;
      hit_idx  <= unit_rsp.free_idx;
      hit_addr <= chk_idx;
    end
    if (state == S_FREE_MOD) begin
      res_status <= ST_OK;
    end
    if (state == S_WRITE) begin
      res_status  <= ST_OK;
      res_frame   <= {hit_addr, hit_idx};
      res_present <= 1'b1;
      res_user    <= user;
      res_write   <= wrb;
    end
    if (out_load) begin
      rsp.status    <= res_status;
      rsp.frame_out <= res_frame;
      rsp.present   <= res_present;
      rsp.user_out  <= res_user;
      rsp.write_out <= res_write;
    end
  end

endmodule

FILE: design/bitmap_frame_allocator_core.sv
// Bitmap first-fit frame allocator, top level.
// Uses bfa_pkg, bfa_req_if, bfa_rsp_if, bfa_ctrl, bfa_word_unit and bfa_ram.
//
// Usage:
//   req  : one request item (allocate or free) under valid/ready.
//   rsp  : one result item per request under valid/ready.
//   cfg_we/cfg_data : write of frame_count; only whole 32-frame words below
//          frame_count are searched. Write only while the block is idle.
// Sequence:
//   A request is taken only while the sequencer is idle. A refused request
//   or a free of frame zero goes straight to the result state; a free
//   reads its word, then modifies and writes it, then gives its result. An
//   allocation scans the bitmap one word per cycle through the single read
//   port of the bitmap RAM, pipelined with the check in the word unit; the
//   first word with a clear bit is written back with that bit set.
// Reset:
//   Synchronous rst clears the per-word valid flags, so the whole map reads
//   as free at once; frame_count returns to 4096. No clearing pass is needed.
// Stall:
//   A finished result waits in the output register; a new request may be
//   taken meanwhile, and its result waits until the previous one is taken.

module bitmap_frame_allocator_core (
  input  logic                      clk,
  input  logic                      rst,
  bfa_req_if.sink                   req,
  bfa_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CNT_W-1:0] cfg_data
);
  import bfa_pkg::*;

  logic [CNT_W-1:0]     frame_count;
  logic [WCNT_W-1:0]    words_raw;
  logic [WCNT_W-1:0]    words;
  logic [WORD_BITS-1:0] ram_rdata;
  ram_ctl_t             ram_ctl;
  unit_req_t            unit_req;
  unit_rsp_t            unit_rsp;

  // Frame count register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= CNT_W'(NUM_FRAMES);
    end else if (cfg_we) begin
      frame_count <= cfg_data;
    end
  end

  // Saturate the searched word count to the map
  assign words_raw = WCNT_W'(frame_count >> BIT_W);
  assign words     = (words_raw > WCNT_W'(MAP_WORDS)) ? WCNT_W'(MAP_WORDS) : words_raw;

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .words     (words),
    .ram_rdata (ram_rdata),
    .ram_ctl   (ram_ctl),
    .unit_req  (unit_req),
    .unit_rsp  (unit_rsp)
  );

  bfa_word_unit u_word_unit (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wdata),
    .raddr (ram_ctl.raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: bench/bitmap_frame_allocator_core_tb.sv
// Self-checking testbench for bitmap_frame_allocator_core: own bitmap predictor,
// directed and random allocate/free traffic, random idling and output back-pressure.
// Depends on bfa_pkg, bfa_req_if, bfa_rsp_if and the allocator RTL.

module bitmap_frame_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  localparam int DRAIN_CYCLES = 140;

  typedef struct packed {
    logic               mode;
    logic [FRAME_W-1:0] page_frame;
    logic               user_bit;
    logic               write_bit;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               user_out;
    logic               write_out;
  } rsp_item_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  bitmap_frame_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Predictor state: used-frame bitmap and frame count
  logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
  logic [CNT_W-1:0]     frame_count_q;
  rsp_item_t            expected_q [$];

  int  mismatch_count = 0;
  bit  send_idle = 1'b1;
  bit  rsp_idle  = 1'b1;
  int  stall_left = 0;
  int  rsp_hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_wait(input bit on);
    return on ? int'($urandom_range(0, 19)) : 0;
  endfunction

  function automatic req_item_t make_req(input logic mode, input logic [FRAME_W-1:0] pf,
                                         input logic ub, input logic wb);
    req_item_t it;
    it.mode       = mode;
    it.page_frame = pf;
    it.user_bit   = ub;
    it.write_bit  = wb;
    return it;
  endfunction

  // Work out the entry after one request and update the bitmap
  function automatic rsp_item_t predict_request(input req_item_t it);
    rsp_item_t r;
    int        words;
    int        fr;
    r = '0;
    if (it.mode == MODE_ALLOC) begin
      if (it.page_frame != '0) begin
        r.status = ST_ALREADY;
        r.frame  = it.page_frame;
      end else begin
        words = int'(frame_count_q) / WORD_BITS;
        if (words > MAP_WORDS) words = MAP_WORDS;
        fr = -1;
        // first word with a clear bit, lowest clear bit inside it
        for (int i = 0; i < words && fr < 0; i++)
          if (frame_map[i] != '1)
            for (int j = WORD_BITS - 1; j >= 0; j--)
              if (!frame_map[i][j]) fr = i * WORD_BITS + j;
        if (fr < 0) begin
          r.status = ST_NO_FREE;
        end else begin
          frame_map[fr / WORD_BITS][fr % WORD_BITS] = 1'b1;
          r.status    = ST_OK;
          r.frame     = fr[FRAME_W-1:0];
          r.present   = 1'b1;
          r.user_out  = it.user_bit;
          r.write_out = it.write_bit;
        end
      end
    end else begin
      if (it.page_frame == '0 || int'(it.page_frame) >= NUM_FRAMES) begin
        r.status = ST_BAD_FREE;
      end else begin
        frame_map[it.page_frame / WORD_BITS][it.page_frame % WORD_BITS] = 1'b0;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  // Pick a used frame in 1..below-1 from a random start, else the start itself
  function automatic logic [FRAME_W-1:0] pick_used_frame(input int below);
    int start;
    int f;
    start = $urandom_range(1, below - 1);
    for (int k = 0; k < below - 1; k++) begin
      f = 1 + (start - 1 + k) % (below - 1);
      if (frame_map[f / WORD_BITS][f % WORD_BITS]) return f[FRAME_W-1:0];
    end
    return start[FRAME_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input rsp_item_t want, input rsp_item_t got);
    if (mismatch_count < 10)
      $display("%0t: %s: expected st=%0d fr=%03h p=%0b u=%0b w=%0b, got st=%0d fr=%03h p=%0b u=%0b w=%0b",
               $realtime, what, want.status, want.frame, want.present, want.user_out,
               want.write_out, got.status, got.frame, got.present, got.user_out, got.write_out);
    mismatch_count++;
  endtask

  // Track register writes and accepted items, check each result
  always @(posedge clk) begin : track
    req_item_t taken;
    rsp_item_t want;
    rsp_item_t got;
    if (rst) begin
      foreach (frame_map[i]) frame_map[i] = '0;
      frame_count_q = CNT_W'(4096);
    end else begin
      if (cfg_we) frame_count_q = cfg_data;
      if (req_ch.valid && req_ch.ready) begin
        taken = make_req(req_ch.mode, req_ch.page_frame, req_ch.user_bit, req_ch.write_bit);
        expected_q.push_back(predict_request(taken));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        stall_left    = draw_wait(rsp_idle);
        got.status    = status_t'(rsp_ch.status);
        got.frame     = rsp_ch.frame_out;
        got.present   = rsp_ch.present;
        got.user_out  = rsp_ch.user_out;
        got.write_out = rsp_ch.write_out;
        if (expected_q.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Receiver: a long hold first, else the per-item stall, else take
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        rsp_hold_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input req_item_t it, input int pick_below = 0);
    int gap;
    gap = draw_wait(send_idle);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (pick_below > 1) it.page_frame = pick_used_frame(pick_below);
    req_ch.mode       = it.mode;
    req_ch.page_frame = it.page_frame;
    req_ch.user_bit   = it.user_bit;
    req_ch.write_bit  = it.write_bit;
    req_ch.valid      = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic wait_drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    wait_drain();
    cfg_data = value;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Mostly well-formed allocate/free traffic with some random noise items
  task automatic send_mixed(input int count, input int free_pct, input int noise_pct,
                            input int below);
    int roll;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        rsp_idle  = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < noise_pct)
        send_item(make_req(1'($urandom_range(0, 1)), FRAME_W'($urandom_range(0, 4095)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      else if (roll < noise_pct + free_pct)
        send_item(make_req(MODE_FREE, '0, 1'b0, 1'b0), below);
      else
        send_item(make_req(MODE_ALLOC, '0, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))));
    end
  endtask

  // Every operation, refusals, bad frees and frees of free frames
  task automatic test_directed_requests();
    send_item(make_req(MODE_ALLOC, '0, 1'b1, 1'b1));
    send_item(make_req(MODE_ALLOC, '0, 1'b0, 1'b0));
    send_item(make_req(MODE_ALLOC, '0, 1'b1, 1'b0));
    send_item(make_req(MODE_ALLOC, '0, 1'b0, 1'b1));
    send_item(make_req(MODE_ALLOC, 12'hFFF, 1'b1, 1'b1));
    send_item(make_req(MODE_ALLOC, 12'h800, 1'b1, 1'b1));
    send_item(make_req(MODE_FREE, '0, 1'b1, 1'b1));
    send_item(make_req(MODE_FREE, 12'h002, 1'b1, 1'b1));
    send_item(make_req(MODE_ALLOC, '0, 1'b1, 1'b1));
    send_item(make_req(MODE_FREE, 12'hFFF, 1'b0, 1'b0));
    send_item(make_req(MODE_FREE, 12'hAAA, 1'b0, 1'b1));
    send_item(make_req(MODE_FREE, 12'h555, 1'b1, 1'b0));
    send_item(make_req(MODE_FREE, 12'h001, 1'b0, 1'b0));
    send_item(make_req(MODE_FREE, 12'h001, 1'b0, 1'b0));
  endtask

  // Empty search range, part word, saturated count and back to reset value
  task automatic test_count_extremes();
    write_count('0);
    send_item(make_req(MODE_ALLOC, '0, 1'b1, 1'b1));
    write_count(CNT_W'(31));
    send_item(make_req(MODE_ALLOC, '0, 1'b1, 1'b0));
    send_item(make_req(MODE_FREE, 12'h003, 1'b0, 1'b0));
    write_count('1);
    send_item(make_req(MODE_ALLOC, '0, 1'b0, 1'b1));
    send_item(make_req(MODE_ALLOC, '0, 1'b1, 1'b1));
    write_count(CNT_W'(32));
    send_item(make_req(MODE_ALLOC, '0, 1'b1, 1'b1));
    write_count(CNT_W'(4096));
    send_item(make_req(MODE_ALLOC, '0, 1'b0, 1'b0));
  endtask

  // Small search ranges, allocation-heavy so that they run out of frames
  task automatic test_exhaust_small_maps();
    int limit;
    for (int r = 0; r < 4; r++) begin
      limit = $urandom_range(1, 4) * WORD_BITS + $urandom_range(0, WORD_BITS - 1);
      write_count(limit[CNT_W-1:0]);
      send_mixed(80, 15, 10, limit);
    end
  endtask

  // Fill the low part of the map so that later searches run deep
  task automatic test_deep_scan();
    write_count(CNT_W'(4096));
    send_mixed(300, 5, 5, NUM_FRAMES);
  endtask

  // Hold the result channel off while the sender keeps offering items
  task automatic test_output_backpressure();
    wait_drain();
    send_idle = 1'b0;
    @(posedge clk);
    rsp_hold_left = 400;
    for (int n = 0; n < 30; n++)
      if (n % 3 == 0)
        send_item(make_req(MODE_FREE, '0, 1'b0, 1'b0), NUM_FRAMES);
      else
        send_item(make_req(MODE_ALLOC, '0, n[0], n[1]));
  endtask

  // Random traffic under several frame counts
  task automatic test_random_mix();
    int counts [4];
    int below;
    counts = '{8191, 1000, 4096, 2065};
    foreach (counts[i]) begin
      write_count(counts[i][CNT_W-1:0]);
      below = (counts[i] > NUM_FRAMES) ? NUM_FRAMES : counts[i];
      send_mixed(170, 30, 15, below);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    req_ch.valid         = 1'b0;
    req_ch.mode          = MODE_ALLOC;
    req_ch.page_frame    = '0;
    req_ch.user_bit      = 1'b0;
    req_ch.write_bit     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_requests();
    test_count_extremes();
    test_exhaust_small_maps();
    test_deep_scan();
    test_output_backpressure();
    test_random_mix();

    // drain, then let any stray result show up
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0)
      $display("bitmap_frame_allocator_core verification clean");
    else
      $display("bitmap_frame_allocator_core verification failed");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("bitmap_frame_allocator_core verification failed");
    $finish;
  end

endmodule

FILE: files.f
design/bfa_pkg.sv
design/bfa_req_if.sv
design/bfa_rsp_if.sv
design/bfa_ram.sv
design/bfa_word_unit.sv
design/bfa_ctrl.sv
design/bitmap_frame_allocator_core.sv
bench/bitmap_frame_allocator_core_tb.sv
